### hdl/assert_macros.svh
// assertion macros used by the formatter datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CHK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### hdl/ifmt_pkg.sv
// types, constants and helpers of the integer field formatter
package ifmt_pkg;

    localparam int MAX_FIELD  = 64;
    localparam int POS_W      = $clog2(MAX_FIELD + 1);
    localparam int MAG_W      = 64;
    localparam int FW_W       = 7;
    localparam int PREC_W     = 6;
    localparam int CHAR_W     = 8;
    localparam int DEC_DIGITS = 20;
    localparam int HEX_DIGITS = MAG_W / 4;
    localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);
    localparam int NDS_W      = $clog2(DEC_DIGITS + 1);
    localparam int BITCNT_W   = $clog2(MAG_W + 1);
    localparam int IN_FIELDS_W = MAG_W + 3 + FW_W + PREC_W + 5 + POS_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // input tdata field offsets
    localparam int OFS_NEG   = MAG_W;
    localparam int OFS_HEX   = OFS_NEG + 1;
    localparam int OFS_UPPER = OFS_HEX + 1;
    localparam int OFS_FW    = OFS_UPPER + 1;
    localparam int OFS_PREC  = OFS_FW + FW_W;
    localparam int OFS_HPREC = OFS_PREC + PREC_W;
    localparam int OFS_LEFT  = OFS_HPREC + 1;
    localparam int OFS_ZPAD  = OFS_LEFT + 1;
    localparam int OFS_PLUS  = OFS_ZPAD + 1;
    localparam int OFS_SPACE = OFS_PLUS + 1;
    localparam int OFS_ROOM  = OFS_SPACE + 1;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_START,
        ST_LEAD,
        ST_SIGN,
        ST_ZERO,
        ST_DIGIT,
        ST_TRAIL
    } t_state;

    typedef enum logic [2:0] {
        SEC_LEAD,
        SEC_SIGN,
        SEC_ZERO,
        SEC_DIGIT,
        SEC_TRAIL
    } t_sect;

    typedef struct packed {
        logic  capture;
        logic  conv_step;
        logic  size;
        logic  load;
        t_sect load_sect;
        logic  emit;
        t_sect sect;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic out_free;
        logic sec_one;
        logic lead_nz;
        logic sign_nz;
        logic zero_nz;
        logic trail_nz;
    } t_stat;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

### hdl/integer_field_formatter_core.sv
// printf style integer field formatter, top level
//
//  channel   dir  tdata                          tuser  tlast
//  s_axis    in   item fields, 92 of 96 bits     -      -
//  m_axis    out  char_out[7:0]                  fits   last
//
//  one input beat yields 1 to 64 output beats, one per cycle when m_axis is ready.
//  decimal conversion is a bit-serial binary to bcd shift; hex loads at once.
//  per item: capture, conversion (done at once for hex), sizing and a start step, then the characters.
//  s_axis is ready only while no item is in work; m_axis stalls hold the sequencer.
//  synchronous active-low reset clears the sequencer and the output valid.
module integer_field_formatter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // magnitude, negative, hex_base, upper_case, field_width, min_digits,
    // has_precision, left_align, zero_pad, force_plus, space_sign, room, zero fill
    input  logic [ifmt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // char_out
    output logic [ifmt_pkg::CHAR_W-1:0]      o_m_axis_tdata,
    // fits
    output logic                             o_m_axis_tuser,
    output logic                             o_m_axis_tlast
);
    import ifmt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ifmt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    ifmt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

### hdl/ifmt_ctrl.sv
// sequencer: conversion, sizing and the five sections of the field
module ifmt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  ifmt_pkg::t_stat i_stat,
    output ifmt_pkg::t_cmd  o_cmd
);
    import ifmt_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state after_lead;
    t_state after_sign;
    t_state after_digit;
    t_state first_sec;
    logic   emit;

    function automatic t_sect state_sect(input t_state s);
        t_sect r;
        case (s)
            ST_LEAD:  r = SEC_LEAD;
            ST_SIGN:  r = SEC_SIGN;
            ST_ZERO:  r = SEC_ZERO;
            ST_DIGIT: r = SEC_DIGIT;
            ST_TRAIL: r = SEC_TRAIL;
            default:  r = SEC_DIGIT;
        endcase
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign emit = (r_state inside {ST_LEAD, ST_SIGN, ST_ZERO, ST_DIGIT, ST_TRAIL})
                  && i_stat.out_free;

    // skip empty sections
    always_comb begin
        after_sign  = i_stat.zero_nz ? ST_ZERO : ST_DIGIT;
        after_lead  = i_stat.sign_nz ? ST_SIGN : after_sign;
        first_sec   = i_stat.lead_nz ? ST_LEAD : after_lead;
        after_digit = i_stat.trail_nz ? ST_TRAIL : ST_IDLE;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_stat.conv_done) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE:  n_state = ST_START;
            ST_START: n_state = first_sec;
            ST_LEAD: begin
                if (emit && i_stat.sec_one) begin
                    n_state = after_lead;
                end
            end
            ST_SIGN: begin
                if (emit && i_stat.sec_one) begin
                    n_state = after_sign;
                end
            end
            ST_ZERO: begin
                if (emit && i_stat.sec_one) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (emit && i_stat.sec_one) begin
                    n_state = after_digit;
                end
            end
            ST_TRAIL: begin
                if (emit && i_stat.sec_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready   = (r_state == ST_IDLE);
        o_cmd.capture     = (r_state == ST_IDLE) && i_s_axis_tvalid;
        o_cmd.conv_step   = (r_state == ST_CONV) && !i_stat.conv_done;
        o_cmd.size        = (r_state == ST_SIZE);
        o_cmd.emit        = emit;
        o_cmd.sect        = state_sect(r_state);
        o_cmd.load_sect   = state_sect(n_state);
        o_cmd.load        = (r_state == ST_START)
                            || (emit && i_stat.sec_one && n_state != ST_IDLE);
    end

endmodule

### hdl/ifmt_dpath.sv
// digit conversion, field sizing and character generation
`include "assert_macros.svh"

module ifmt_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [ifmt_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                 i_m_axis_tready,
    input  ifmt_pkg::t_cmd                       i_cmd,
    output ifmt_pkg::t_stat                      o_stat,
    output logic                                 o_m_axis_tvalid,
    output logic [ifmt_pkg::CHAR_W-1:0]          o_m_axis_tdata,
    output logic                                 o_m_axis_tuser,
    output logic                                 o_m_axis_tlast
);
    import ifmt_pkg::*;

    // captured item
    logic [MAG_W-1:0]    r_mag;
    logic [3:0]          r_bcd [DEC_DIGITS];
    logic [BITCNT_W-1:0] r_bitcnt;
    logic                r_neg;
    logic                r_upper;
    logic [FW_W-1:0]     r_fw;
    logic [PREC_W-1:0]   r_prec;
    logic                r_has_prec;
    logic                r_left;
    logic                r_zpad;
    logic                r_plus;
    logic                r_space;
    logic [POS_W-1:0]    r_room;

    // field layout
    logic [NDS_W-1:0]    r_nd_sig;
    logic [PREC_W-1:0]   r_nd_eff;
    logic [POS_W-1:0]    r_pad;
    logic [POS_W-1:0]    r_total;
    logic [CHAR_W-1:0]   r_sign_char;
    logic                r_has_sign;
    logic [POS_W-1:0]    r_sec;
    logic [POS_W-1:0]    r_pos;

    // output register
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_fits;
    logic                r_out_last;

    logic [3:0]          adj [DEC_DIGITS];
    logic [NDS_W-1:0]    nd_sig;
    logic [PREC_W-1:0]   nd_eff;
    logic [FW_W-1:0]     fw_sat;
    logic [POS_W-1:0]    used;
    logic [POS_W-1:0]    pad;
    logic                has_sign;
    logic [CHAR_W-1:0]   sign_char;
    logic [POS_W-1:0]    sec_len;
    logic [POS_W-1:0]    dig_idx;
    logic [CHAR_W-1:0]   ch;
    logic                is_last;

    // shift-and-add-3 correction before each shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mag      <= i_s_axis_tdata[OFS_HEX] ? '0 : i_s_axis_tdata[MAG_W-1:0];
            r_bitcnt   <= i_s_axis_tdata[OFS_HEX] ? '0 : BITCNT_W'(MAG_W);
            for (int i = 0; i < DEC_DIGITS; i++) begin
                r_bcd[i] <= '0;
            end
            for (int i = 0; i < HEX_DIGITS; i++) begin
                if (i_s_axis_tdata[OFS_HEX]) begin
                    r_bcd[i] <= i_s_axis_tdata[4*i +: 4];
                end
            end
            r_neg      <= i_s_axis_tdata[OFS_NEG];
            r_upper    <= i_s_axis_tdata[OFS_UPPER];
            r_fw       <= i_s_axis_tdata[OFS_FW +: FW_W];
            r_prec     <= i_s_axis_tdata[OFS_PREC +: PREC_W];
            r_has_prec <= i_s_axis_tdata[OFS_HPREC];
            r_left     <= i_s_axis_tdata[OFS_LEFT];
            r_zpad     <= i_s_axis_tdata[OFS_ZPAD];
            r_plus     <= i_s_axis_tdata[OFS_PLUS];
            r_space    <= i_s_axis_tdata[OFS_SPACE];
            r_room     <= i_s_axis_tdata[OFS_ROOM +: POS_W];
        end else if (i_cmd.conv_step) begin
            r_mag    <= {r_mag[MAG_W-2:0], 1'b0};
            r_bcd[0] <= {adj[0][2:0], r_mag[MAG_W-1]};
            for (int i = 1; i < DEC_DIGITS; i++) begin
                r_bcd[i] <= {adj[i][2:0], adj[i-1][3]};
            end
            r_bitcnt <= r_bitcnt - BITCNT_W'(1);
        end
    end

    // significant digits, at least one for a zero value
    always_comb begin
        nd_sig = NDS_W'(1);
        for (int i = 1; i < DEC_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                nd_sig = NDS_W'(i + 1);
            end
        end
        nd_eff = (r_has_prec && r_prec > PREC_W'(nd_sig)) ? r_prec : PREC_W'(nd_sig);
        has_sign  = r_neg || r_plus || r_space;
        sign_char = r_neg ? CH_MINUS : (r_plus ? CH_PLUS : CH_SPACE);
        fw_sat    = (r_fw > FW_W'(MAX_FIELD)) ? FW_W'(MAX_FIELD) : r_fw;
        used      = POS_W'(nd_eff) + POS_W'(has_sign);
        pad       = (POS_W'(fw_sat) > used) ? POS_W'(fw_sat) - used : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.size) begin
            r_nd_sig    <= nd_sig;
            r_nd_eff    <= nd_eff;
            r_pad       <= pad;
            r_total     <= used + pad;
            r_has_sign  <= has_sign;
            r_sign_char <= sign_char;
        end
    end

    always_comb begin
        case (i_cmd.load_sect)
            SEC_LEAD:  sec_len = r_pad;
            SEC_SIGN:  sec_len = POS_W'(1);
            SEC_ZERO:  sec_len = r_pad;
            SEC_DIGIT: sec_len = POS_W'(r_nd_eff);
            SEC_TRAIL: sec_len = r_pad;
            default:   sec_len = r_pad;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.size) begin
            r_pos <= '0;
        end else if (i_cmd.emit) begin
            r_pos <= r_pos + POS_W'(1);
        end
        if (i_cmd.load) begin
            r_sec <= sec_len;
        end else if (i_cmd.emit) begin
            r_sec <= r_sec - POS_W'(1);
        end
    end

    // digits leave most significant first; indexes past the value give precision zeros
    always_comb begin
        dig_idx = r_sec - POS_W'(1);
        case (i_cmd.sect)
            SEC_LEAD:  ch = CH_SPACE;
            SEC_SIGN:  ch = r_sign_char;
            SEC_ZERO:  ch = CH_ZERO;
            SEC_DIGIT: begin
                if (dig_idx < POS_W'(r_nd_sig)) begin
                    ch = digit_char(r_bcd[dig_idx[DIG_IDX_W-1:0]], r_upper);
                end else begin
                    ch = CH_ZERO;
                end
            end
            SEC_TRAIL: ch = CH_SPACE;
            default:   ch = CH_SPACE;
        endcase
        is_last = (r_pos == r_total - POS_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_char <= ch;
            r_out_fits <= (r_pos < r_room);
            r_out_last <= is_last;
        end
    end

    always_comb begin
        o_stat.conv_done = (r_bitcnt == '0);
        o_stat.out_free  = !r_out_valid || i_m_axis_tready;
        o_stat.sec_one   = (r_sec == POS_W'(1));
        o_stat.lead_nz   = !r_left && !r_zpad && (r_pad != '0);
        o_stat.sign_nz   = r_has_sign;
        o_stat.zero_nz   = !r_left && r_zpad && (r_pad != '0);
        o_stat.trail_nz  = r_left && (r_pad != '0);
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tuser  = r_out_fits;
    assign o_m_axis_tlast  = r_out_last;

    `ASSERT_CHK(a_emit_in_field, i_clk, i_rst_n, i_cmd.emit |-> (r_pos < r_total))
    `ASSERT_CHK(a_last_ends_sect, i_clk, i_rst_n, (i_cmd.emit && is_last) |-> o_stat.sec_one)
    `ASSERT_CHK(a_emit_shows, i_clk, i_rst_n, i_cmd.emit |=> r_out_valid)
    `ASSERT_NEVER(a_conv_overrun, i_clk, i_rst_n, i_cmd.conv_step && (r_bitcnt == '0))

endmodule

### tb/tb_integer_field_formatter_core.sv
// self-checking testbench of the integer field formatter: directed and random items
`timescale 1ns / 100ps

module tb_integer_field_formatter_core;
    import ifmt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_LEN    = 400;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [63:0] magnitude;
        logic        negative;
        logic        hex_base;
        logic        upper_case;
        logic [6:0]  field_width;
        logic [5:0]  min_digits;
        logic        has_precision;
        logic        left_align;
        logic        zero_pad;
        logic        force_plus;
        logic        space_sign;
        logic [6:0]  room;
    } t_item;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              fits;
        logic              last;
    } t_char_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]     o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    t_item      pending_fields[$];
    t_char_beat expected_chars[$];
    t_item      drv_item;
    logic       s_taken = 1'b0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_on   = 1'b0;
    int hold_cycles  = 0;
    int cycle_count  = 0;
    int fail_count   = 0;
    int items_seen   = 0;
    int chars_seen   = 0;

    integer_field_formatter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_item(input t_item it);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        w[MAG_W-1:0]        = it.magnitude;
        w[OFS_NEG]          = it.negative;
        w[OFS_HEX]          = it.hex_base;
        w[OFS_UPPER]        = it.upper_case;
        w[OFS_FW +: FW_W]   = it.field_width;
        w[OFS_PREC +: PREC_W] = it.min_digits;
        w[OFS_HPREC]        = it.has_precision;
        w[OFS_LEFT]         = it.left_align;
        w[OFS_ZPAD]         = it.zero_pad;
        w[OFS_PLUS]         = it.force_plus;
        w[OFS_SPACE]        = it.space_sign;
        w[OFS_ROOM +: POS_W] = it.room;
        return w;
    endfunction

    function automatic t_item mk(input logic [63:0] mag, input bit neg, input bit hex,
                                 input bit upper, input int fw, input int prec,
                                 input bit hprec, input bit left, input bit zpad,
                                 input bit plus, input bit sp, input int room);
        t_item it;
        it.magnitude     = mag;
        it.negative      = neg;
        it.hex_base      = hex;
        it.upper_case    = upper;
        it.field_width   = 7'(fw);
        it.min_digits    = 6'(prec);
        it.has_precision = hprec;
        it.left_align    = left;
        it.zero_pad      = zpad;
        it.force_plus    = plus;
        it.space_sign    = sp;
        it.room          = 7'(room);
        return it;
    endfunction

    function automatic t_item rand_field_item();
        t_item it;
        case ($urandom_range(9))
            0:       it.magnitude = '0;
            1:       it.magnitude = '1;
            2, 3:    it.magnitude = {$urandom, $urandom};
            default: it.magnitude = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        it.negative      = 1'($urandom_range(1));
        it.hex_base      = 1'($urandom_range(1));
        it.upper_case    = 1'($urandom_range(1));
        // mostly short fields, now and then past the saturation point
        it.field_width   = ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(24));
        it.min_digits    = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                                    : 6'($urandom_range(20));
        it.has_precision = 1'($urandom_range(1));
        it.left_align    = 1'($urandom_range(1));
        it.zero_pad      = 1'($urandom_range(1));
        it.force_plus    = 1'($urandom_range(1));
        it.space_sign    = 1'($urandom_range(1));
        it.room          = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(30));
        return it;
    endfunction

    // builds the printed field of one item and queues its characters
    function automatic void format_field(input t_item it);
        logic [CHAR_W-1:0] rev_digits[$];
        logic [CHAR_W-1:0] text[$];
        logic [MAG_W-1:0]  m;
        logic [3:0]        d;
        logic [CHAR_W-1:0] sign_ch;
        bit                has_sign;
        int                fw, used, pad, k;
        t_char_beat        b;
        m  = it.magnitude;
        fw = (it.field_width > MAX_FIELD) ? MAX_FIELD : int'(it.field_width);
        if (m == '0)
            rev_digits.push_back(CH_ZERO);
        while (m != '0 && rev_digits.size() < MAX_FIELD - 1) begin
            if (it.hex_base) begin
                d = m[3:0];
                m = m >> 4;
            end else begin
                d = 4'(m % 64'd10);
                m = m / 64'd10;
            end
            if (d < 4'd10)
                rev_digits.push_back(CH_ZERO + 8'(d));
            else
                rev_digits.push_back((it.upper_case ? CH_UA : CH_LA) + 8'(d) - 8'd10);
        end
        if (it.has_precision)
            while (rev_digits.size() < int'(it.min_digits) && rev_digits.size() < MAX_FIELD - 1)
                rev_digits.push_back(CH_ZERO);

        has_sign = 1'b1;
        sign_ch  = CH_SPACE;
        if (it.negative)
            sign_ch = CH_MINUS;
        else if (it.force_plus)
            sign_ch = CH_PLUS;
        else if (!it.space_sign)
            has_sign = 1'b0;

        used = rev_digits.size() + (has_sign ? 1 : 0);
        pad  = (fw > used) ? fw - used : 0;

        if (!it.left_align && !it.zero_pad)
            for (k = 0; k < pad; k++) text.push_back(CH_SPACE);
        if (has_sign)
            text.push_back(sign_ch);
        if (!it.left_align && it.zero_pad)
            for (k = 0; k < pad; k++) text.push_back(CH_ZERO);
        for (k = rev_digits.size() - 1; k >= 0; k--)
            text.push_back(rev_digits[k]);
        if (it.left_align)
            for (k = 0; k < pad; k++) text.push_back(CH_SPACE);

        for (k = 0; k < text.size(); k++) begin
            b.ch   = text[k];
            b.fits = (k < int'(it.room));
            b.last = (k == text.size() - 1);
            expected_chars.push_back(b);
        end
    endfunction

    // sender: a beat stays up until taken, new beats only after a gap decision
    always @(negedge i_clk) begin : drive_proc
        t_item nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || s_taken) begin
            if (pending_fields.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = pending_fields.pop_front();
                drv_item        <= nxt;
                i_s_axis_tdata  <= pack_item(nxt);
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        hold_cycles <= rx_hold_on ? hold_cycles + 1 : 0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_m_axis_tready <= 1'b0;
        else if (rx_hold_on && hold_cycles < HOLD_LEN)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin : monitor_proc
        t_char_beat want;
        int         errs;
        errs = 0;
        s_taken <= i_s_axis_tvalid && o_s_axis_tready && i_rst_n;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                format_field(drv_item);
                items_seen <= items_seen + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                chars_seen <= chars_seen + 1;
                if (expected_chars.size() == 0) begin
                    $error("output beat with nothing expected: char_out %h", o_m_axis_tdata);
                    errs++;
                end else begin
                    want = expected_chars.pop_front();
                    if (o_m_axis_tdata !== want.ch) begin
                        $error("char_out: expected %h, got %h", want.ch, o_m_axis_tdata);
                        errs++;
                    end
                    if (o_m_axis_tuser !== want.fits) begin
                        $error("fits: expected %b, got %b", want.fits, o_m_axis_tuser);
                        errs++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, o_m_axis_tlast);
                        errs++;
                    end
                end
            end
        end
        fail_count <= fail_count + errs;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_fields.size() != 0 || i_s_axis_tvalid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int ph, n;
        bit chars_lost;
        chars_lost = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, sign priority, alignment and padding corners
        pending_fields.push_back(mk(64'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64));
        pending_fields.push_back(mk(64'd0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 64));
        pending_fields.push_back(mk('1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 127));
        pending_fields.push_back(mk('1, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 127));
        pending_fields.push_back(mk('1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 8));
        pending_fields.push_back(mk(64'hABCDEF, 0, 1, 0, 10, 0, 0, 0, 1, 0, 0, 64));
        pending_fields.push_back(mk(64'd42, 1, 0, 0, 6, 0, 0, 0, 0, 1, 1, 64));
        pending_fields.push_back(mk(64'd42, 0, 0, 0, 6, 0, 0, 0, 0, 1, 1, 64));
        pending_fields.push_back(mk(64'd42, 0, 0, 0, 6, 0, 0, 0, 0, 0, 1, 64));
        pending_fields.push_back(mk(64'd99, 1, 0, 0, 12, 0, 0, 1, 1, 0, 0, 64));
        pending_fields.push_back(mk(64'd7, 0, 0, 0, 8, 3, 1, 0, 1, 0, 0, 64));
        pending_fields.push_back(mk(64'd1, 1, 0, 0, 0, 63, 1, 0, 0, 0, 0, 64));
        pending_fields.push_back(mk(64'hBEEF, 0, 1, 1, 127, 63, 1, 0, 1, 1, 0, 127));
        pending_fields.push_back(mk(64'd5, 0, 0, 0, 127, 0, 0, 0, 0, 0, 0, 127));
        pending_fields.push_back(mk(64'd5, 0, 0, 0, 64, 0, 0, 0, 0, 0, 0, 0));
        pending_fields.push_back(mk(64'd5, 0, 0, 0, 64, 0, 0, 1, 0, 0, 0, 64));
        pending_fields.push_back(mk(64'd31337, 0, 0, 0, 20, 0, 0, 0, 0, 0, 0, 10));
        pending_fields.push_back(mk(64'd1234567890, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5));
        pending_fields.push_back(mk(64'h8000000000000000, 1, 0, 0, 30, 0, 0, 0, 1, 1, 0, 64));
        pending_fields.push_back(mk(64'hFEDCBA9876543210, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 64));
        pending_fields.push_back(mk(64'd77, 0, 0, 0, 0, 20, 0, 0, 0, 0, 0, 64));
        pending_fields.push_back(mk(64'd9, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        pending_fields.push_back(mk(64'd3, 1, 1, 1, 4, 2, 1, 1, 0, 1, 1, 2));
        wait_drained();

        // long output hold while the sender keeps offering
        rx_hold_on = 1'b1;
        for (n = 0; n < 6; n++)
            pending_fields.push_back(rand_field_item());
        wait_drained();
        rx_hold_on = 1'b0;

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
            endcase
            for (n = 0; n < 23; n++)
                pending_fields.push_back(rand_field_item());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            $error("%0d expected characters never arrived", expected_chars.size());
            chars_lost = 1'b1;
        end

        $display("formatted %0d items into %0d characters, %0d mismatches", items_seen,
                 chars_seen, fail_count);
        $display("covered directed corners, a long output hold and four idle profiles");
        if (fail_count == 0 && !chars_lost)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
